// ===== src/fpl_pkg.sv =====
// shared types, constants and field helpers for the face phong lighting block
package fpl_pkg;

    // field geometry
    localparam int COORD_W   = 16;
    localparam int CHAN_W    = 16;
    localparam int FIELD_W   = 48;
    localparam int FRAC_BITS = 14;

    // internal number formats
    localparam int UNIT_FRAC = 30;
    localparam int UNIT_W    = UNIT_FRAC + 2;
    localparam int COS_FRAC  = 16;
    localparam int NORM_BITS = 24;
    localparam int S_W       = 2 * NORM_BITS + 2;
    localparam int SPEC_SQ   = 5;

    // normalize unit depth: four front stages, root steps, quotient steps, sign stage
    localparam int SQRT_STEPS = NORM_BITS + 1;
    localparam int DIV_STEPS  = UNIT_FRAC + 1;
    localparam int UNIT_LAT   = 4 + SQRT_STEPS + DIV_STEPS + 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_POSITION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COLOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K_AMBIENT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_K_DIFFUSE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_K_SPECULAR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE_ENABLE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECULAR_ENABLE = 3'd6;

    // register reset values
    localparam logic [FIELD_W-1:0] COLOR_RESET = 48'h4000_4000_4000;
    localparam logic [CHAN_W-1:0]  K_RESET     = 16'h4000;

    typedef logic [2:0][UNIT_W-1:0] t_uvec;

    typedef struct packed {
        logic [FIELD_W-1:0] corner_a;
        logic [FIELD_W-1:0] corner_b;
        logic [FIELD_W-1:0] corner_d;
        logic [FIELD_W-1:0] light_position;
        logic [FIELD_W-1:0] light_ambient;
        logic [FIELD_W-1:0] light_diffuse;
    } t_in;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_out;

    // signed coordinate idx of a packed position, x lowest
    function automatic logic signed [COORD_W-1:0] coord(input logic [FIELD_W-1:0] p,
                                                       input int idx);
        return p[idx*COORD_W +: COORD_W];
    endfunction

    // unsigned channel idx of a packed color, r lowest
    function automatic logic [CHAN_W-1:0] chan(input logic [FIELD_W-1:0] p, input int idx);
        return p[idx*CHAN_W +: CHAN_W];
    endfunction

endpackage

// ===== src/fpl_delay.sv =====
// enabled delay line that keeps side data aligned with the pipeline
module fpl_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_tap [DEPTH];

    // shift one place per enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];
endmodule

// ===== src/fpl_unit.sv =====
// pipelined vector normalize: block scale, bit-serial square root, per-bit divide
module fpl_unit #(
    parameter int IN_W = 36
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [2:0][IN_W-1:0] i_vec,
    output fpl_pkg::t_uvec       o_unit
);
    import fpl_pkg::*;

    localparam int BL_W  = $clog2(IN_W + 1);
    localparam int WX    = IN_W + NORM_BITS;
    localparam int LEN_W = NORM_BITS + 1;
    localparam int REM_W = LEN_W + 1;
    localparam int SX_W  = S_W + 1;
    localparam int Q_W   = DIV_STEPS;

    // front stages
    logic [2:0][IN_W-1:0]        r_mag_a, n_mag_a;
    logic [2:0]                  r_sgn_a, r_sgn_b, r_sgn_c;
    logic                        r_any_a, r_any_b, r_any_c;
    logic [2:0][NORM_BITS-1:0]   r_nm_b, n_nm_b, r_nm_c;
    logic [2:0][2*NORM_BITS-1:0] r_sq_c;
    logic [IN_W-1:0]             w_or;
    logic [BL_W-1:0]             w_bl;
    logic [WX-1:0]               w_wide;
    logic [S_W-1:0]              w_sum;

    // root steps
    logic [SX_W-1:0]             r_sx [SQRT_STEPS+1];
    logic [SX_W-1:0]             r_sr [SQRT_STEPS+1];
    logic [SX_W-1:0]             n_sx [SQRT_STEPS];
    logic [SX_W-1:0]             n_sr [SQRT_STEPS];
    logic [SX_W-1:0]             w_trial [SQRT_STEPS];
    logic [2:0][NORM_BITS-1:0]   r_cm [SQRT_STEPS+1];
    logic [2:0]                  r_cs [SQRT_STEPS+1];
    logic                        r_ca [SQRT_STEPS+1];

    // quotient steps
    logic [2:0][REM_W-1:0]       r_dr [DIV_STEPS];
    logic [2:0][REM_W-1:0]       n_dr [DIV_STEPS];
    logic [2:0][Q_W-1:0]         r_dq [DIV_STEPS];
    logic [2:0][Q_W-1:0]         n_dq [DIV_STEPS];
    logic [LEN_W-1:0]            r_dl [DIV_STEPS];
    logic [2:0]                  r_ds [DIV_STEPS];
    logic                        r_da [DIV_STEPS];
    logic [REM_W-1:0]            w_rem2;
    logic [REM_W-1:0]            w_len;
    logic                        w_ge;

    t_uvec                       r_out, n_out;
    logic [UNIT_W-1:0]           w_q;

    // magnitudes and block scale
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag_a[k] = i_vec[k][IN_W-1] ? (~i_vec[k] + IN_W'(1)) : i_vec[k];
        end
        w_or = r_mag_a[0] | r_mag_a[1] | r_mag_a[2];
        w_bl = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (w_or[i]) begin
                w_bl = BL_W'(i + 1);
            end
        end
        w_wide = '0;
        for (int k = 0; k < 3; k++) begin
            w_wide = WX'(r_mag_a[k]);
            if (int'(w_bl) > NORM_BITS) begin
                w_wide = w_wide >> (int'(w_bl) - NORM_BITS);
            end else begin
                w_wide = w_wide << (NORM_BITS - int'(w_bl));
            end
            n_nm_b[k] = w_wide[NORM_BITS-1:0];
        end
        w_sum = S_W'(r_sq_c[0]) + S_W'(r_sq_c[1]) + S_W'(r_sq_c[2]);
    end

    // one root bit per step
    always_comb begin
        for (int j = 0; j < SQRT_STEPS; j++) begin
            w_trial[j] = r_sr[j] + (SX_W'(1) << (2 * (SQRT_STEPS - 1 - j)));
            if (r_sx[j] >= w_trial[j]) begin
                n_sx[j] = r_sx[j] - w_trial[j];
                n_sr[j] = (r_sr[j] >> 1) + (SX_W'(1) << (2 * (SQRT_STEPS - 1 - j)));
            end else begin
                n_sx[j] = r_sx[j];
                n_sr[j] = r_sr[j] >> 1;
            end
        end
    end

    // one quotient bit per step, top bit first
    always_comb begin
        w_rem2 = '0;
        w_ge   = 1'b0;
        w_len  = REM_W'(r_sr[SQRT_STEPS][LEN_W-1:0]);
        for (int k = 0; k < 3; k++) begin
            w_rem2     = REM_W'(r_cm[SQRT_STEPS][k]);
            w_ge       = w_rem2 >= w_len;
            n_dr[0][k] = w_ge ? (w_rem2 - w_len) : w_rem2;
            n_dq[0][k] = Q_W'(w_ge) << (Q_W - 1);
        end
        for (int j = 1; j < DIV_STEPS; j++) begin
            for (int k = 0; k < 3; k++) begin
                w_rem2     = {r_dr[j-1][k][REM_W-2:0], 1'b0};
                w_ge       = w_rem2 >= REM_W'(r_dl[j-1]);
                n_dr[j][k] = w_ge ? (w_rem2 - REM_W'(r_dl[j-1])) : w_rem2;
                n_dq[j][k] = r_dq[j-1][k] | (Q_W'(w_ge) << (Q_W - 1 - j));
            end
        end
    end

    // restore signs, zero vector gives zero
    always_comb begin
        w_q = '0;
        for (int k = 0; k < 3; k++) begin
            w_q = UNIT_W'(r_dq[DIV_STEPS-1][k]);
            if (!r_da[DIV_STEPS-1]) begin
                n_out[k] = '0;
            end else if (r_ds[DIV_STEPS-1][k]) begin
                n_out[k] = -w_q;
            end else begin
                n_out[k] = w_q;
            end
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_a <= n_mag_a;
            for (int k = 0; k < 3; k++) begin
                r_sgn_a[k] <= i_vec[k][IN_W-1];
            end
            r_any_a <= |{i_vec[0], i_vec[1], i_vec[2]};
            r_nm_b  <= n_nm_b;
            r_sgn_b <= r_sgn_a;
            r_any_b <= r_any_a;
            for (int k = 0; k < 3; k++) begin
                r_sq_c[k] <= r_nm_b[k] * r_nm_b[k];
            end
            r_nm_c  <= r_nm_b;
            r_sgn_c <= r_sgn_b;
            r_any_c <= r_any_b;
            r_sx[0] <= SX_W'(w_sum);
            r_sr[0] <= '0;
            r_cm[0] <= r_nm_c;
            r_cs[0] <= r_sgn_c;
            r_ca[0] <= r_any_c;
            for (int j = 0; j < SQRT_STEPS; j++) begin
                r_sx[j+1] <= n_sx[j];
                r_sr[j+1] <= n_sr[j];
                r_cm[j+1] <= r_cm[j];
                r_cs[j+1] <= r_cs[j];
                r_ca[j+1] <= r_ca[j];
            end
            r_dl[0] <= r_sr[SQRT_STEPS][LEN_W-1:0];
            r_ds[0] <= r_cs[SQRT_STEPS];
            r_da[0] <= r_ca[SQRT_STEPS];
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_dr[j] <= n_dr[j];
                r_dq[j] <= n_dq[j];
            end
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_dl[j] <= r_dl[j-1];
                r_ds[j] <= r_ds[j-1];
                r_da[j] <= r_da[j-1];
            end
            r_out <= n_out;
        end
    end

    assign o_unit = r_out;
endmodule

// ===== src/face_phong_lighting_top.sv =====
// flat phong shading pipeline, one face and light per beat
// throughput: one beat per cycle while the output is not stalled
// the depth comes from four 61-stage normalize units,
// two in parallel for normal and light, two in parallel for reflection and eye
// a stall at the output holds every stage; nothing is lost or repeated
// reset (synchronous, active low) empties the pipeline and loads the register defaults
module face_phong_lighting_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  fpl_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output fpl_pkg::t_out                      o_out_data,
    input  logic                               i_cfg_we,
    input  logic [fpl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fpl_pkg::FIELD_W-1:0]        i_cfg_data
);
    import fpl_pkg::*;

    localparam int NST    = 2 * UNIT_LAT + 19;
    localparam int D_W    = COORD_W + 1;
    localparam int P_W    = 2 * D_W;
    localparam int N_W    = P_W + 1;
    localparam int R_W    = 36;
    localparam int PR_W   = 2 * UNIT_W;
    localparam int DOT_W  = PR_W + 2;
    localparam int C_W    = DOT_W - UNIT_FRAC;
    localparam int NC_W   = UNIT_W + C_W;
    localparam int COS_W  = UNIT_FRAC + 1;
    localparam int C16_W  = COS_FRAC + 1;
    localparam int SIDE1_W = 3 * D_W + 2 * FIELD_W;
    localparam int SIDE2_W = COS_W + 2 * FIELD_W;
    localparam int AMB_W  = 3 * CHAN_W - 2 * FRAC_BITS;
    localparam int DF_W   = 3 * CHAN_W - FRAC_BITS;
    localparam int DIF_W  = DF_W + C16_W - COS_FRAC - FRAC_BITS;
    localparam int S2_W   = 2 * CHAN_W + C16_W;
    localparam int SPE_W  = S2_W - COS_FRAC - FRAC_BITS;
    localparam int SUM_W  = DIF_W + 1;
    localparam logic [COS_W-1:0] ONE = COS_W'(1) << UNIT_FRAC;

    // configuration registers
    logic [FIELD_W-1:0] r_cam, r_color;
    logic [CHAN_W-1:0]  r_ka, r_kd, r_ks;
    logic               r_den, r_sen;

    // flow control
    logic [NST-1:0]     r_vld;
    logic               w_en;

    // front stages
    t_in                         r_in;
    logic signed [D_W-1:0]       r_u1 [3], r_w1 [3], r_dv1 [3], r_ev1 [3];
    logic signed [D_W-1:0]       r_dv2 [3], r_ev2 [3];
    logic [2:0][D_W-1:0]         r_dv3, r_ev3;
    logic signed [P_W-1:0]       r_pr2 [6];
    logic [2:0][N_W-1:0]         r_n3;
    logic [FIELD_W-1:0]          r_la1, r_ld1, r_la2, r_ld2, r_la3, r_ld3;

    // first cosine and reflection
    t_uvec                       w_nu, w_du, r_nu1, r_nu2, r_du1, r_du2, r_du3;
    logic signed [PR_W-1:0]      r_dp [3];
    logic signed [C_W-1:0]       r_c2;
    logic [COS_W-1:0]            r_cosd2, r_cosd3, r_cosd4;
    logic signed [NC_W-1:0]      r_nc3 [3];
    logic [2:0][R_W-1:0]         r_r4;
    logic [SIDE1_W-1:0]          w_side1;
    logic [2:0][D_W-1:0]         w_ev_r;
    logic [FIELD_W-1:0]          w_la_r, w_ld_r;

    // second cosine and power
    t_uvec                       w_ru, w_eu;
    logic signed [PR_W-1:0]      r_ep [3];
    logic [COS_W-1:0]            r_spec [SPEC_SQ+1];
    logic [SIDE2_W-1:0]          w_side2;
    logic [COS_W-1:0]            w_cosd_k;
    logic [FIELD_W-1:0]          w_la_k, w_ld_k;

    // color stages
    logic [2*CHAN_W-1:0]         r_a1 [3], r_d1 [3], r_s1 [3];
    logic [C16_W-1:0]            r_cd1, r_sp1, r_cd2;
    logic [3*CHAN_W-1:0]         r_a2 [3], r_d2 [3];
    logic [S2_W-1:0]             r_s2 [3];
    logic [AMB_W-1:0]            r_amb [3];
    logic [DIF_W-1:0]            r_dif [3];
    logic [SPE_W-1:0]            r_spe [3];
    t_out                        r_out;

    // comb temps
    logic signed [DOT_W-1:0]     w_dot, w_adot, w_sdot, w_asdot;
    logic signed [C_W-1:0]       w_c, w_s;
    logic [COS_W-1:0]            w_cosd, w_coss;
    logic [DF_W+C16_W-1:0]       w_dprod [3];
    logic [SUM_W-1:0]            w_sum [3];
    logic [2*COS_W-1:0]          w_sq [SPEC_SQ];

    // whole pipeline moves unless the output beat is stuck
    assign w_en        = !r_vld[NST-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[NST-1];
    assign o_out_data  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam   <= '0;
            r_color <= COLOR_RESET;
            r_ka    <= K_RESET;
            r_kd    <= K_RESET;
            r_ks    <= K_RESET;
            r_den   <= 1'b1;
            r_sen   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAM_POSITION:    r_cam   <= i_cfg_data;
                CFG_OBJECT_COLOR:    r_color <= i_cfg_data;
                CFG_K_AMBIENT:       r_ka    <= i_cfg_data[CHAN_W-1:0];
                CFG_K_DIFFUSE:       r_kd    <= i_cfg_data[CHAN_W-1:0];
                CFG_K_SPECULAR:      r_ks    <= i_cfg_data[CHAN_W-1:0];
                CFG_DIFFUSE_ENABLE:  r_den   <= i_cfg_data[0];
                CFG_SPECULAR_ENABLE: r_sen   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // valid bits ride alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // input beat, edge vectors, cross product
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in <= i_in_data;
            for (int k = 0; k < 3; k++) begin
                r_u1[k]  <= D_W'(coord(r_in.corner_b, k)) - D_W'(coord(r_in.corner_a, k));
                r_w1[k]  <= D_W'(coord(r_in.corner_d, k)) - D_W'(coord(r_in.corner_a, k));
                r_dv1[k] <= D_W'(coord(r_in.light_position, k))
                          - D_W'(coord(r_in.corner_a, k));
                r_ev1[k] <= D_W'(coord(r_in.corner_a, k)) - D_W'(coord(r_cam, k));
            end
            r_la1 <= r_in.light_ambient;
            r_ld1 <= r_in.light_diffuse;
            r_pr2[0] <= r_u1[1] * r_w1[2];
            r_pr2[1] <= r_u1[2] * r_w1[1];
            r_pr2[2] <= r_u1[2] * r_w1[0];
            r_pr2[3] <= r_u1[0] * r_w1[2];
            r_pr2[4] <= r_u1[0] * r_w1[1];
            r_pr2[5] <= r_u1[1] * r_w1[0];
            r_dv2 <= r_dv1;
            r_ev2 <= r_ev1;
            r_la2 <= r_la1;
            r_ld2 <= r_ld1;
            for (int k = 0; k < 3; k++) begin
                r_n3[k]  <= N_W'(r_pr2[2*k]) - N_W'(r_pr2[2*k+1]);
                r_dv3[k] <= r_dv2[k];
                r_ev3[k] <= r_ev2[k];
            end
            r_la3 <= r_la2;
            r_ld3 <= r_ld2;
        end
    end

    // normal and light direction
    fpl_unit #(.IN_W(N_W)) u_nu (.i_clk(i_clk), .i_en(w_en), .i_vec(r_n3), .o_unit(w_nu));
    fpl_unit #(.IN_W(D_W)) u_du (.i_clk(i_clk), .i_en(w_en), .i_vec(r_dv3), .o_unit(w_du));

    // eye vector and light colors wait for the reflection
    fpl_delay #(.W(SIDE1_W), .DEPTH(UNIT_LAT + 4)) u_side1 (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_ev3, r_la3, r_ld3}), .o_q(w_side1)
    );
    assign {w_ev_r, w_la_r, w_ld_r} = w_side1;

    // diffuse cosine and reflected vector
    always_comb begin
        w_dot  = DOT_W'(r_dp[0]) + DOT_W'(r_dp[1]) + DOT_W'(r_dp[2]);
        w_adot = w_dot[DOT_W-1] ? -w_dot : w_dot;
        w_adot = w_adot >>> UNIT_FRAC;
        w_c    = w_dot[DOT_W-1] ? -C_W'(w_adot) : C_W'(w_adot);
        if (w_c > 0) begin
            w_cosd = (w_c > $signed({1'b0, C_W'(ONE)})) ? ONE : w_c[COS_W-1:0];
        end else begin
            w_cosd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_dp[k] <= $signed(w_nu[k]) * $signed(w_du[k]);
            end
            r_nu1   <= w_nu;
            r_du1   <= w_du;
            r_c2    <= w_c;
            r_cosd2 <= w_cosd;
            r_nu2   <= r_nu1;
            r_du2   <= r_du1;
            for (int k = 0; k < 3; k++) begin
                r_nc3[k] <= $signed(r_nu2[k]) * r_c2;
            end
            r_du3   <= r_du2;
            r_cosd3 <= r_cosd2;
            r_r4    <= n_r4(r_nc3, r_du3, r_cosd3);
            r_cosd4 <= r_cosd3;
        end
    end

    // r = d - 2 * trunc(n * c), forced to zero when there is no diffuse light
    function automatic logic [2:0][R_W-1:0] n_r4(input logic signed [NC_W-1:0] nc [3],
                                                input t_uvec du,
                                                input logic [COS_W-1:0] cosd);
        logic signed [NC_W-1:0] anc;
        logic signed [NC_W-1:0] t;
        logic [2:0][R_W-1:0]    r;
        for (int k = 0; k < 3; k++) begin
            anc  = nc[k][NC_W-1] ? -nc[k] : nc[k];
            anc  = anc >>> UNIT_FRAC;
            t    = nc[k][NC_W-1] ? -anc : anc;
            r[k] = (cosd != '0) ? (R_W'($signed(du[k])) - (R_W'(t) << 1)) : '0;
        end
        return r;
    endfunction

    // reflected and eye directions
    fpl_unit #(.IN_W(R_W)) u_ru (.i_clk(i_clk), .i_en(w_en), .i_vec(r_r4), .o_unit(w_ru));
    fpl_unit #(.IN_W(D_W)) u_eu (.i_clk(i_clk), .i_en(w_en), .i_vec(w_ev_r), .o_unit(w_eu));

    // diffuse cosine and colors wait for the specular power
    fpl_delay #(.W(SIDE2_W), .DEPTH(UNIT_LAT + 7)) u_side2 (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_cosd4, w_la_r, w_ld_r}), .o_q(w_side2)
    );
    assign {w_cosd_k, w_la_k, w_ld_k} = w_side2;

    // specular cosine and five squarings
    always_comb begin
        w_sdot  = DOT_W'(r_ep[0]) + DOT_W'(r_ep[1]) + DOT_W'(r_ep[2]);
        w_asdot = w_sdot[DOT_W-1] ? -w_sdot : w_sdot;
        w_asdot = w_asdot >>> UNIT_FRAC;
        w_s     = w_sdot[DOT_W-1] ? -C_W'(w_asdot) : C_W'(w_asdot);
        if (w_s > 0) begin
            w_coss = (w_s > $signed({1'b0, C_W'(ONE)})) ? ONE : w_s[COS_W-1:0];
        end else begin
            w_coss = '0;
        end
        for (int i = 0; i < SPEC_SQ; i++) begin
            w_sq[i] = r_spec[i] * r_spec[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_ep[k] <= $signed(w_ru[k]) * $signed(w_eu[k]);
            end
            r_spec[0] <= w_coss;
            for (int i = 0; i < SPEC_SQ; i++) begin
                r_spec[i+1] <= w_sq[i][UNIT_FRAC +: COS_W];
            end
        end
    end

    // color terms and saturation
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_dprod[k] = (DF_W + C16_W)'(r_d2[k] >> FRAC_BITS) * r_cd2;
            w_sum[k]   = SUM_W'(r_amb[k]) + SUM_W'(r_dif[k]) + SUM_W'(r_spe[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a1[k] <= chan(w_la_k, k) * r_ka;
                r_d1[k] <= chan(w_ld_k, k) * chan(r_color, k);
                r_s1[k] <= chan(w_ld_k, k) * r_ks;
                r_a2[k] <= r_a1[k] * chan(r_color, k);
                r_d2[k] <= r_d1[k] * r_kd;
                r_s2[k] <= r_s1[k] * r_sp1;
                r_amb[k] <= r_a2[k][2*FRAC_BITS +: AMB_W];
                r_dif[k] <= r_den ? w_dprod[k][COS_FRAC+FRAC_BITS +: DIF_W] : '0;
                r_spe[k] <= r_sen ? r_s2[k][COS_FRAC+FRAC_BITS +: SPE_W] : '0;
            end
            r_cd1 <= w_cosd_k[UNIT_FRAC-COS_FRAC +: C16_W];
            r_sp1 <= r_spec[SPEC_SQ][UNIT_FRAC-COS_FRAC +: C16_W];
            r_cd2 <= r_cd1;
            r_out.red   <= (w_sum[0] > SUM_W'({CHAN_W{1'b1}})) ? '1 : w_sum[0][CHAN_W-1:0];
            r_out.green <= (w_sum[1] > SUM_W'({CHAN_W{1'b1}})) ? '1 : w_sum[1][CHAN_W-1:0];
            r_out.blue  <= (w_sum[2] > SUM_W'({CHAN_W{1'b1}})) ? '1 : w_sum[2][CHAN_W-1:0];
        end
    end
endmodule

// ===== src/fpl_checker.sv =====
// port-level checks for the lighting pipeline, bound to the top level
module fpl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input fpl_pkg::t_out o_out_data
);
    import fpl_pkg::*;

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // input side only stalls when the output side does
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output flow");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");
endmodule

bind face_phong_lighting_top fpl_checker u_fpl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
